/* rtl/core/button_debounce_edge_hold_reset_macros.svh */
// Assertion macros shared by the button debounce block.
`ifndef BUTTON_DEBOUNCE_EDGE_HOLD_RESET_MACROS_SVH
`define BUTTON_DEBOUNCE_EDGE_HOLD_RESET_MACROS_SVH

`ifndef NO_ASSERTIONS
// A condition that must hold in the same cycle as its trigger.
`define BDE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bde assertion failed");
// A condition that must hold in the cycle after its trigger.
`define BDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bde assertion failed");
`else
`define BDE_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define BDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/core/bde_pkg.sv */
// Shared types and constants of the button debounce block.
`timescale 1ns / 1ps
package bde_pkg;

  // Field widths.
  localparam int unsigned TIME_W = 32;
  localparam int unsigned RAW_W = 8;
  localparam int unsigned MS_W = 16;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Default button count.
  localparam int unsigned NUM_BUTTONS_DEF = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_IDX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_IDX = 2'd3;

  // Register reset values.
  localparam logic [MS_W-1:0] DEBOUNCE_MS_RST = 16'd100;
  localparam logic [MS_W-1:0] HOLD_MS_RST = 16'd2000;
  localparam logic [IDX_W-1:0] RESET_IDX_RST = 3'd0;
  localparam logic [IDX_W-1:0] START_IDX_RST = 3'd1;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [MS_W-1:0]  debounce_ms;
    logic [MS_W-1:0]  hold_ms;
    logic [IDX_W-1:0] reset_button_index;
    logic [IDX_W-1:0] start_button_index;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [RAW_W-1:0] pressed_mask;
    logic [RAW_W-1:0] new_press_mask;
    logic             reset_request;
  } result_t;

endpackage

/* rtl/core/bde_cfg.sv */
// Configuration register file of the button debounce block.
`timescale 1ns / 1ps
module bde_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bde_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bde_pkg::MS_W-1:0]       cfg_data_i,
  output bde_pkg::cfg_t                  cfg_o
);
  import bde_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Register decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE_MS: cfg_d.debounce_ms = cfg_data_i;
        CFG_HOLD_MS:     cfg_d.hold_ms = cfg_data_i;
        CFG_RESET_IDX:   cfg_d.reset_button_index = cfg_data_i[IDX_W-1:0];
        CFG_START_IDX:   cfg_d.start_button_index = cfg_data_i[IDX_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= DEBOUNCE_MS_RST;
      cfg_q.hold_ms <= HOLD_MS_RST;
      cfg_q.reset_button_index <= RESET_IDX_RST;
      cfg_q.start_button_index <= START_IDX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/bde_debounce.sv */
// Per-button debounce state with press time stamps and edge detection.
`timescale 1ns / 1ps
`include "button_debounce_edge_hold_reset_macros.svh"
module bde_debounce #(
  parameter int unsigned NUM_BUTTONS = bde_pkg::NUM_BUTTONS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  bde_pkg::cfg_t               cfg_i,
  input  logic [bde_pkg::TIME_W-1:0]  now_ms_i,
  input  logic [bde_pkg::RAW_W-1:0]   raw_levels_i,
  output logic [bde_pkg::RAW_W-1:0]   pressed_mask_o,
  output logic [bde_pkg::RAW_W-1:0]   new_press_mask_o
);
  import bde_pkg::*;

  logic [NUM_BUTTONS-1:0] pressed_q, pressed_d;
  logic [NUM_BUTTONS-1:0] level;
  logic [TIME_W-1:0]      stamp_q [NUM_BUTTONS];
  logic [TIME_W-1:0]      stamp_d [NUM_BUTTONS];
  logic [TIME_W-1:0]      elapsed [NUM_BUTTONS];
  logic [TIME_W-1:0]      debounce_ext;

  assign debounce_ext = TIME_W'(cfg_i.debounce_ms);

  // Buttons beyond the raw field read as released.
  for (genvar gi = 0; gi < NUM_BUTTONS; gi++) begin : g_level
    if (gi < RAW_W) begin : g_raw
      assign level[gi] = raw_levels_i[gi];
    end else begin : g_high
      assign level[gi] = 1'b1;
    end
  end

  // A button samples its level only once its hold-off has run out; a low
  // level marks it pressed and restamps its press time.
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      elapsed[i] = now_ms_i - stamp_q[i];
      pressed_d[i] = pressed_q[i];
      stamp_d[i] = stamp_q[i];
      if (elapsed[i] > debounce_ext) begin
        pressed_d[i] = ~level[i];
        if (!level[i]) begin
          stamp_d[i] = now_ms_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        stamp_q[i] <= '0;
      end
    end else if (push_i) begin
      pressed_q <= pressed_d;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        stamp_q[i] <= stamp_d[i];
      end
    end
  end

  // Output masks show the low buttons only; missing buttons read as zero.
  for (genvar gb = 0; gb < RAW_W; gb++) begin : g_mask
    if (gb < NUM_BUTTONS) begin : g_btn
      assign pressed_mask_o[gb] = pressed_d[gb];
      assign new_press_mask_o[gb] = pressed_d[gb] & ~pressed_q[gb];
    end else begin : g_none
      assign pressed_mask_o[gb] = 1'b0;
      assign new_press_mask_o[gb] = 1'b0;
    end
  end

  // A new press is always a button that is pressed.
  `BDE_ASSERT_NOW(a_new_press_pressed, clk_i, rst_ni, 1'b1,
                  (new_press_mask_o & ~pressed_mask_o) == '0)

endmodule

/* rtl/core/bde_chord.sv */
// Two-button reset chord hold timer.
`timescale 1ns / 1ps
`include "button_debounce_edge_hold_reset_macros.svh"
module bde_chord (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  bde_pkg::cfg_t               cfg_i,
  input  logic [bde_pkg::TIME_W-1:0]  now_ms_i,
  input  logic [bde_pkg::RAW_W-1:0]   pressed_mask_i,
  output logic                        reset_request_o
);
  import bde_pkg::*;

  logic              active_q, active_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [TIME_W-1:0] held;
  logic              chord;

  // Buttons that do not exist read as zero in the mask, so an index past
  // the button count never completes the chord.
  assign chord = pressed_mask_i[cfg_i.reset_button_index] &
                 pressed_mask_i[cfg_i.start_button_index];

  // The request needs a chord that was already running before this poll.
  assign held = now_ms_i - start_q;
  assign reset_request_o = chord & active_q & (held > TIME_W'(cfg_i.hold_ms));

  // Chord onset records the start time; a broken chord clears the timer.
  always_comb begin
    active_d = active_q;
    start_d = start_q;
    if (push_i) begin
      active_d = chord;
      if (chord && !active_q) begin
        start_d = now_ms_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  // The start time is written at chord onset before it is ever used.
  always_ff @(posedge clk_i) begin
    start_q <= start_d;
  end

  // A request only comes from a running chord.
  `BDE_ASSERT_NOW(a_request_needs_chord, clk_i, rst_ni, reset_request_o,
                  active_q && chord)

endmodule

/* rtl/core/bde_outbuf.sv */
// Two-entry result buffer: an output register and a skid register.
`timescale 1ns / 1ps
`include "button_debounce_edge_hold_reset_macros.svh"
module bde_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bde_pkg::result_t  result_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bde_pkg::result_t  result_o
);
  import bde_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = out_valid_q & ~out_stall_i;

  // A new request goes to the output register when it is free or being
  // taken, otherwise it waits in the skid register.
  always_comb begin
    out_valid_d = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d = out_q;
    skid_d = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d = result_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d = result_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    skid_q <= skid_d;
  end

  assign full_o = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign result_o = out_q;

  // The skid register is used only behind a waiting output register.
  `BDE_ASSERT_NOW(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  // A full buffer that is stalled stays full.
  `BDE_ASSERT_NEXT(a_full_holds, clk_i, rst_ni, skid_valid_q && out_stall_i,
                   skid_valid_q && out_valid_q)

endmodule

/* rtl/core/button_debounce_edge_hold_reset.sv */
// Top level of the button debounce block with edge detect and reset chord.
// Each accepted request is one poll: a millisecond time stamp and the
// active-low raw button levels. A poll is accepted in every cycle unless the
// input is stalled. Its result is registered at the same edge and is shown on
// the output from the next cycle when the output register is free. The whole
// update of the press stamps, the debounced mask and the chord timer is done
// in one pass at the input edge, so the block runs at one poll per clock when
// not stalled. A two-entry result buffer lets a poll be accepted while an
// earlier result is still waiting; the input is stalled only while both
// entries are held. Button states are frozen for debounce_ms after a press,
// and the reset request is raised on each poll after the chord has been held
// beyond hold_ms. No clearing pass is needed after reset.
`timescale 1ns / 1ps
module button_debounce_edge_hold_reset #(
  parameter int unsigned NUM_BUTTONS = bde_pkg::NUM_BUTTONS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bde_pkg::TIME_W-1:0]     now_ms_i,
  input  logic [bde_pkg::RAW_W-1:0]      raw_levels_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bde_pkg::RAW_W-1:0]      pressed_mask_o,
  output logic [bde_pkg::RAW_W-1:0]      new_press_mask_o,
  output logic                           reset_request_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bde_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bde_pkg::MS_W-1:0]       cfg_data_i
);
  import bde_pkg::*;

  cfg_t             cfg;
  logic             push;
  logic             full;
  logic [RAW_W-1:0] pressed_mask;
  logic [RAW_W-1:0] new_press_mask;
  logic             reset_request;
  result_t          result_in;
  result_t          result_out;

  assign in_stall_o = full;
  assign push = in_valid_i & ~full;

  // Configuration registers.
  bde_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Debounce and edge detection.
  bde_debounce #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .cfg_i            (cfg),
    .now_ms_i         (now_ms_i),
    .raw_levels_i     (raw_levels_i),
    .pressed_mask_o   (pressed_mask),
    .new_press_mask_o (new_press_mask)
  );

  // Reset chord timer.
  bde_chord u_chord (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .cfg_i           (cfg),
    .now_ms_i        (now_ms_i),
    .pressed_mask_i  (pressed_mask),
    .reset_request_o (reset_request)
  );

  // Result buffer.
  always_comb begin
    result_in.pressed_mask = pressed_mask;
    result_in.new_press_mask = new_press_mask;
    result_in.reset_request = reset_request;
  end

  bde_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .result_i    (result_in),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_out)
  );

  assign pressed_mask_o = result_out.pressed_mask;
  assign new_press_mask_o = result_out.new_press_mask;
  assign reset_request_o = result_out.reset_request;

endmodule
